/* rtl/atsd_pkg.sv */
// Package for the alpha threshold square dilation block: sizes, register
// indexes, command codes, beat and control structs, and the sequencer states.
// No dependencies; every other file refers to it by scoped names.
package atsd_pkg;

   // Frame and window limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_RADIUS = 8;

   // One line store bank per row of the tallest window, plus the rows that the
   // input runs ahead of the window bottom when a row is narrower than the radius
   localparam int NUM_BANKS = 3 * MAX_RADIUS + 1;
   localparam int WIN_COLS  = 2 * MAX_RADIUS + 1;
   localparam int BANK_W    = $clog2(NUM_BANKS);
   localparam int COL_AW    = $clog2(MAX_WIDTH);

   // Field and counter widths
   localparam int DIM_W     = 11;
   localparam int RADIUS_W  = 4;
   localparam int ALPHA_W   = 8;
   localparam int MASK_W    = 8;
   localparam int COL_W     = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
   localparam int PIX_CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS          = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 2'd3;

   localparam logic [DIM_W-1:0]    FRAME_WIDTH_RESET     = 11'd1024;
   localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RESET    = 11'd1024;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET          = 4'd1;
   localparam logic [ALPHA_W-1:0]  ALPHA_THRESHOLD_RESET = 8'd40;

   // Command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Mask values
   localparam logic [MASK_W-1:0] MASK_ON  = 8'd255;
   localparam logic [MASK_W-1:0] MASK_OFF = 8'd0;

   typedef struct packed {
      logic               command;
      logic [ALPHA_W-1:0] alpha;
   } atsd_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              last_of_frame;
   } atsd_rsp_type;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [RADIUS_W-1:0] radius;
      logic [ALPHA_W-1:0]  threshold;
   } atsd_cfg_type;

   // Line store access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [BANK_W-1:0] wr_bank;
      logic [COL_AW-1:0] wr_addr;
      logic              wr_bit;
      logic [COL_AW-1:0] rd_addr;
   } atsd_mem_cmd_type;

   // Window control from the sequencer
   typedef struct packed {
      logic              clear;
      logic              shift;
      logic              col_ok;
      logic [BANK_W-1:0] out_bank;
      logic [DIM_W-1:0]  out_row;
   } atsd_win_ctl_type;

   // Result hand-off to the output register
   typedef struct packed {
      logic load;
      logic last;
   } atsd_emit_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SETTLE,
      ST_EMIT
   } atsd_state_type;

endpackage

/* rtl/atsd_line_store.sv */
// Line store: one bit per pixel for the last rows of the frame, one bank per
// stored row, all banks read together at one column. Uses atsd_pkg.
module atsd_line_store (
   input  logic                           clock,
   input  atsd_pkg::atsd_mem_cmd_type     mem_cmd,
   output logic [atsd_pkg::NUM_BANKS-1:0] col_bits
);

   logic [atsd_pkg::NUM_BANKS-1:0] line_mem [atsd_pkg::MAX_WIDTH];
   logic [atsd_pkg::NUM_BANKS-1:0] col_bits_ff;

   // Write one bank bit, read the whole column into a register
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         line_mem[mem_cmd.wr_addr][mem_cmd.wr_bank] <= mem_cmd.wr_bit;
      end
      col_bits_ff <= line_mem[mem_cmd.rd_addr];
   end

   assign col_bits = col_bits_ff;

endmodule

/* rtl/atsd_window.sv */
// Window: vertical OR of a line store column over the rows in the window, and
// a shift register of column results for the horizontal OR. Uses atsd_pkg.
module atsd_window (
   input  logic                           clock,
   input  logic                           reset,
   input  atsd_pkg::atsd_cfg_type         cfg,
   input  atsd_pkg::atsd_win_ctl_type     win_ctl,
   input  logic [atsd_pkg::NUM_BANKS-1:0] col_bits,
   output logic                           hit
);

   localparam int REL_W  = atsd_pkg::BANK_W + 1;
   localparam int ROW_W  = atsd_pkg::DIM_W + 1;
   localparam int SPAN_W = atsd_pkg::RADIUS_W + 1;

   logic [REL_W-1:0]               rel_sum  [atsd_pkg::NUM_BANKS];
   logic [REL_W-1:0]               rel      [atsd_pkg::NUM_BANKS];
   logic [REL_W-1:0]               nrel     [atsd_pkg::NUM_BANKS];
   logic [atsd_pkg::NUM_BANKS-1:0] row_mask;
   logic [atsd_pkg::WIN_COLS-1:0]  win_mask;
   logic [atsd_pkg::WIN_COLS-1:0]  hist_ff;
   logic [SPAN_W-1:0]              twice_r;
   logic                           shift_ff;
   logic                           ok_ff;

   // Pick the banks whose rows sit inside both the window and the frame
   always_comb begin
      for (int b = 0; b < atsd_pkg::NUM_BANKS; b++) begin
         rel_sum[b] = REL_W'(b + atsd_pkg::NUM_BANKS) - REL_W'(win_ctl.out_bank);
         rel[b]     = (rel_sum[b] >= REL_W'(atsd_pkg::NUM_BANKS)) ?
                      rel_sum[b] - REL_W'(atsd_pkg::NUM_BANKS) : rel_sum[b];
         nrel[b]    = REL_W'(atsd_pkg::NUM_BANKS) - rel[b];
         if (rel[b] <= REL_W'(atsd_pkg::MAX_RADIUS)) begin
            // row at or below the center row
            row_mask[b] = (ROW_W'(rel[b]) <= ROW_W'(cfg.radius)) &&
                          (ROW_W'(win_ctl.out_row) + ROW_W'(rel[b]) < ROW_W'(cfg.height));
         end else begin
            // row above the center row
            row_mask[b] = (ROW_W'(nrel[b]) <= ROW_W'(cfg.radius)) &&
                          (ROW_W'(win_ctl.out_row) >= ROW_W'(nrel[b]));
         end
      end
   end

   // Keep only the newest 2r+1 columns
   assign twice_r = {cfg.radius, 1'b0};
   always_comb begin
      for (int k = 0; k < atsd_pkg::WIN_COLS; k++) begin
         win_mask[k] = SPAN_W'(k) <= twice_r;
      end
   end

   // Track which read data is arriving
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         shift_ff <= win_ctl.shift;
         ok_ff    <= win_ctl.col_ok;
      end
   end

   // Clear at a row start, shift in each column result as it arrives
   always_ff @(posedge clock) begin
      if (win_ctl.clear) begin
         hist_ff <= '0;
      end else if (shift_ff) begin
         hist_ff <= {hist_ff[atsd_pkg::WIN_COLS-2:0], ok_ff & (|(col_bits & row_mask))};
      end
   end

   assign hit = |(hist_ff & win_mask);

endmodule

/* rtl/atsd_ctrl.sv */
// Sequencer: raster counters for input and output, line store writes, the
// column reads for each result, and the result hand-off. Uses atsd_pkg.
module atsd_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  atsd_pkg::atsd_cfg_type        cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  atsd_pkg::atsd_req_type        req_payload,
   input  logic                          slot_free,
   output atsd_pkg::atsd_mem_cmd_type    mem_cmd,
   output atsd_pkg::atsd_win_ctl_type    win_ctl,
   output atsd_pkg::atsd_emit_type       emit
);

   localparam int PW = atsd_pkg::PIX_CNT_W;

   atsd_pkg::atsd_state_type          state_ff;
   atsd_pkg::atsd_state_type          state_in;
   logic [atsd_pkg::DIM_W-1:0]        in_col_ff;
   logic [atsd_pkg::DIM_W-1:0]        in_row_ff;
   logic [atsd_pkg::BANK_W-1:0]       in_bank_ff;
   logic [atsd_pkg::DIM_W-1:0]        out_col_ff;
   logic [atsd_pkg::DIM_W-1:0]        out_row_ff;
   logic [atsd_pkg::BANK_W-1:0]       out_bank_ff;
   logic [PW-1:0]                     diff_ff;
   logic [atsd_pkg::COL_W-1:0]        rd_col_ff;
   logic [atsd_pkg::RADIUS_W-1:0]     rd_cnt_ff;
   logic [PW-1:0]                     lag;
   logic                              accept;
   logic                              is_pix;
   logic                              pix_emit;
   logic                              drain_emit;
   logic                              start_emit;
   logic                              emit_done;
   logic                              last_pix;
   logic                              row_start;

   // Output lag in pixels: radius rows plus radius pixels
   assign lag = PW'(cfg.radius) * PW'(cfg.width) + PW'(cfg.radius);

   assign accept     = req_valid && !req_stall;
   assign is_pix     = (req_payload.command == atsd_pkg::CMD_PIXEL) &&
                       (in_row_ff < cfg.height);
   assign pix_emit   = is_pix && (diff_ff >= lag) && (out_row_ff < cfg.height);
   assign drain_emit = !is_pix && (in_row_ff >= cfg.height) && (out_row_ff < cfg.height);
   assign start_emit = accept && (pix_emit || drain_emit);
   assign emit_done  = (state_ff == atsd_pkg::ST_EMIT) && slot_free;
   assign last_pix   = (out_row_ff == cfg.height - atsd_pkg::DIM_W'(1)) &&
                       (out_col_ff == cfg.width - atsd_pkg::DIM_W'(1));
   assign row_start  = (out_col_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      priority if (restart) begin
         state_in = atsd_pkg::ST_IDLE;
      end else begin
         unique case (state_ff)
            atsd_pkg::ST_IDLE: begin
               if (start_emit) state_in = atsd_pkg::ST_READ;
            end
            atsd_pkg::ST_READ: begin
               if (rd_cnt_ff == '0) state_in = atsd_pkg::ST_SETTLE;
            end
            atsd_pkg::ST_SETTLE: begin
               state_in = atsd_pkg::ST_EMIT;
            end
            atsd_pkg::ST_EMIT: begin
               if (slot_free) state_in = atsd_pkg::ST_IDLE;
            end
            default: begin
               state_in = atsd_pkg::ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atsd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall        = (state_ff != atsd_pkg::ST_IDLE);
      mem_cmd.wr_en    = accept && is_pix;
      mem_cmd.wr_bank  = in_bank_ff;
      mem_cmd.wr_addr  = in_col_ff[atsd_pkg::COL_AW-1:0];
      mem_cmd.wr_bit   = (req_payload.alpha >= cfg.threshold);
      mem_cmd.rd_addr  = rd_col_ff[atsd_pkg::COL_AW-1:0];
      win_ctl.clear    = start_emit && row_start;
      win_ctl.shift    = (state_ff == atsd_pkg::ST_READ);
      win_ctl.col_ok   = (rd_col_ff < atsd_pkg::COL_W'(cfg.width));
      win_ctl.out_bank = out_bank_ff;
      win_ctl.out_row  = out_row_ff;
      emit.load        = emit_done;
      emit.last        = last_pix;
   end

   // Raster counters; a register write or the last result restarts the frame
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_bank_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_bank_ff <= '0;
         diff_ff     <= '0;
      end else begin
         // advance the input position on a stored pixel
         if (accept && is_pix) begin
            diff_ff <= diff_ff + PW'(1);
            if (in_col_ff == cfg.width - atsd_pkg::DIM_W'(1)) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + atsd_pkg::DIM_W'(1);
               in_bank_ff <= (in_bank_ff == atsd_pkg::BANK_W'(atsd_pkg::NUM_BANKS - 1)) ?
                             '0 : in_bank_ff + atsd_pkg::BANK_W'(1);
            end else begin
               in_col_ff <= in_col_ff + atsd_pkg::DIM_W'(1);
            end
         end
         // advance the output position on a delivered result
         if (emit_done) begin
            if (last_pix) begin
               in_col_ff   <= '0;
               in_row_ff   <= '0;
               in_bank_ff  <= '0;
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_bank_ff <= '0;
               diff_ff     <= '0;
            end else begin
               diff_ff <= diff_ff - PW'(1);
               if (out_col_ff == cfg.width - atsd_pkg::DIM_W'(1)) begin
                  out_col_ff <= '0;
                  out_row_ff <= out_row_ff + atsd_pkg::DIM_W'(1);
                  out_bank_ff <= (out_bank_ff == atsd_pkg::BANK_W'(atsd_pkg::NUM_BANKS - 1)) ?
                                 '0 : out_bank_ff + atsd_pkg::BANK_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + atsd_pkg::DIM_W'(1);
               end
            end
         end
      end
   end

   // Column reads: columns 0..r at a row start, else only the new right column
   always_ff @(posedge clock) begin
      if (start_emit) begin
         if (row_start) begin
            rd_col_ff <= '0;
            rd_cnt_ff <= cfg.radius;
         end else begin
            rd_col_ff <= atsd_pkg::COL_W'(out_col_ff) + atsd_pkg::COL_W'(cfg.radius);
            rd_cnt_ff <= '0;
         end
      end else if (state_ff == atsd_pkg::ST_READ) begin
         rd_col_ff <= rd_col_ff + atsd_pkg::COL_W'(1);
         rd_cnt_ff <= rd_cnt_ff - atsd_pkg::RADIUS_W'(1);
      end
   end

endmodule

/* rtl/alpha_threshold_square_dilation.sv */
// Top level of the alpha threshold square dilation block: register port,
// clamping of the settings, and the result register. Uses atsd_pkg,
// atsd_line_store, atsd_window and atsd_ctrl.
//
// Alphas enter in raster order and are thresholded into a bit line store of
// one bank per stored row (25 banks of 1024 bits: the window rows plus the
// rows that the input runs ahead on frames narrower than the radius), read a
// whole column at a time through one read port. A beat that yields no mask
// leaves the block ready for the next beat. A beat that yields a mask passes
// through store write, column read, read settle and result; at the first
// pixel of each output row, columns 0 to radius are read one per cycle
// through the single read port; a stalled result register adds its stall
// time. Masks trail the alphas by radius rows plus radius pixels; drain beats
// flush the rest of the frame after its last alpha. Any register write
// restarts the frame. The store needs no clearing after reset.
module alpha_threshold_square_dilation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  atsd_pkg::atsd_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output atsd_pkg::atsd_rsp_type              rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [atsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [atsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [atsd_pkg::DIM_W-1:0]     frame_width_ff;
   logic [atsd_pkg::DIM_W-1:0]     frame_height_ff;
   logic [atsd_pkg::RADIUS_W-1:0]  radius_ff;
   logic [atsd_pkg::ALPHA_W-1:0]   alpha_threshold_ff;
   atsd_pkg::atsd_cfg_type         cfg;
   logic                           restart;
   logic                           slot_free;
   logic                           hit;
   logic [atsd_pkg::NUM_BANKS-1:0] col_bits;
   atsd_pkg::atsd_mem_cmd_type     mem_cmd;
   atsd_pkg::atsd_win_ctl_type     win_ctl;
   atsd_pkg::atsd_emit_type        emit;
   logic                           rsp_valid_ff;
   atsd_pkg::atsd_rsp_type         rsp_payload_ff;

   // Register writes are always taken
   assign csr_ready = 1'b1;
   assign restart   = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff     <= atsd_pkg::FRAME_WIDTH_RESET;
         frame_height_ff    <= atsd_pkg::FRAME_HEIGHT_RESET;
         radius_ff          <= atsd_pkg::RADIUS_RESET;
         alpha_threshold_ff <= atsd_pkg::ALPHA_THRESHOLD_RESET;
      end else if (restart) begin
         unique case (csr_index)
            atsd_pkg::CSR_FRAME_WIDTH:     frame_width_ff  <= csr_wdata[atsd_pkg::DIM_W-1:0];
            atsd_pkg::CSR_FRAME_HEIGHT:    frame_height_ff <= csr_wdata[atsd_pkg::DIM_W-1:0];
            atsd_pkg::CSR_RADIUS:          radius_ff       <= csr_wdata[atsd_pkg::RADIUS_W-1:0];
            atsd_pkg::CSR_ALPHA_THRESHOLD: begin
               alpha_threshold_ff <= csr_wdata[atsd_pkg::ALPHA_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp zero up to one and large values down to the limits
   always_comb begin
      cfg.width = (frame_width_ff == '0) ? atsd_pkg::DIM_W'(1) :
                  (frame_width_ff > atsd_pkg::DIM_W'(atsd_pkg::MAX_WIDTH)) ?
                  atsd_pkg::DIM_W'(atsd_pkg::MAX_WIDTH) : frame_width_ff;
      cfg.height = (frame_height_ff == '0) ? atsd_pkg::DIM_W'(1) :
                   (frame_height_ff > atsd_pkg::DIM_W'(atsd_pkg::MAX_HEIGHT)) ?
                   atsd_pkg::DIM_W'(atsd_pkg::MAX_HEIGHT) : frame_height_ff;
      cfg.radius = (radius_ff == '0) ? atsd_pkg::RADIUS_W'(1) :
                   (radius_ff > atsd_pkg::RADIUS_W'(atsd_pkg::MAX_RADIUS)) ?
                   atsd_pkg::RADIUS_W'(atsd_pkg::MAX_RADIUS) : radius_ff;
      cfg.threshold = alpha_threshold_ff;
   end

   atsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .slot_free   (slot_free),
      .mem_cmd     (mem_cmd),
      .win_ctl     (win_ctl),
      .emit        (emit)
   );

   atsd_line_store u_line_store (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .col_bits (col_bits)
   );

   atsd_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .win_ctl  (win_ctl),
      .col_bits (col_bits),
      .hit      (hit)
   );

   // Result register: load when empty or being taken, drop once taken
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.load) begin
         rsp_payload_ff.mask          <= hit ? atsd_pkg::MASK_ON : atsd_pkg::MASK_OFF;
         rsp_payload_ff.last_of_frame <= emit.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
